// ===== rtl/fvg_pkg.sv =====
package fvg_pkg;

    // FAT type codes
    localparam logic [1:0] FAT12 = 2'd0;
    localparam logic [1:0] FAT16 = 2'd1;
    localparam logic [1:0] FAT32 = 2'd2;

    // Divider lanes, one per FAT type
    localparam int LANES     = 3;
    localparam int LANE_F12  = 0;
    localparam int LANE_F16  = 1;
    localparam int LANE_F32  = 2;

    localparam logic [7:0] MAX_CLUSTER = 8'd128;
    localparam logic [31:0] F16_MIN_CLUSTERS = 32'd4085;
    localparam logic [31:0] F32_MIN_CLUSTERS = 32'd65525;
    localparam int ROOT_BYTES = 16384;

    typedef struct packed {
        logic [31:0] volume_sectors;
        logic [7:0]  requested_cluster_sectors;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  fat_kind;
        logic [7:0]  cluster_sectors;
        logic [31:0] cluster_total;
        logic [25:0] fat_sectors;
        logic [5:0]  reserved_sectors;
        logic [16:0] root_dir_bytes;
        logic [15:0] short_sector_field;
        logic [31:0] long_sector_field;
        logic        too_small;
    } out_item_t;

    // Data that rides along the divider pipeline
    typedef struct packed {
        logic [31:0] sectors;
        logic [7:0]  cs;
        logic        tiny;
    } side_t;

endpackage

// ===== rtl/fvg_prep.sv =====
module fvg_prep
    import fvg_pkg::*;
#(
    parameter int SECTOR_BYTES = 512
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       en,
    input  logic                                       in_valid,
    input  in_item_t                                   in_item,
    output logic                                       out_valid,
    output side_t                                      out_side,
    output logic [LANES-1:0][32+$clog2(SECTOR_BYTES)-1:0] out_num,
    output logic [LANES-1:0][$clog2(SECTOR_BYTES)+8:0]    out_den
);

    localparam int SBW = $clog2(SECTOR_BYTES);
    localparam int DW  = 32 + SBW;
    localparam int VW  = SBW + 9;
    localparam int ROOT_SECS = (ROOT_BYTES + SECTOR_BYTES - 1) / SECTOR_BYTES;
    localparam logic [31:0] MIN_SECS = 32'(ROOT_SECS + 2);

    logic        valid_reg;
    side_t       side_reg, side_next;
    logic [LANES-1:0][DW-1:0] num_reg, num_next;
    logic [LANES-1:0][VW-1:0] den_reg, den_next;

    logic [31:0] sec;
    logic [7:0]  req;
    logic [7:0]  cs;
    logic        tiny;
    logic [31:0] data12;
    logic [31:0] data32;
    logic [VW-1:0] base;

    always_comb begin
        sec = in_item.volume_sectors;
        req = in_item.requested_cluster_sectors;
        // Default ladder, thresholds in sectors
        if (req == 8'd0) begin
            if (sec >= 32'h2000_0000)      cs = 8'd128;
            else if (sec >= 32'h0800_0000) cs = 8'd64;
            else if (sec >= 32'h0200_0000) cs = 8'd32;
            else if (sec >= 32'h0100_0000) cs = 8'd16;
            else if (sec >= 32'h0004_0000) cs = 8'd8;
            else if (sec >= 32'h0002_0000) cs = 8'd4;
            else if (sec >= 32'h0001_0000) cs = 8'd2;
            else                           cs = 8'd1;
        end else if (req > MAX_CLUSTER) begin
            cs = MAX_CLUSTER;
        end else begin
            cs = req;
        end
        tiny   = sec < MIN_SECS;
        data12 = tiny ? 32'd0 : sec - MIN_SECS;
        data32 = sec - 32'd32;
        base   = {1'b0, cs, {SBW{1'b0}}};

        num_next[LANE_F12] = {data12, {SBW{1'b0}}};
        num_next[LANE_F16] = {data12, {SBW{1'b0}}};
        num_next[LANE_F32] = {data32, {SBW{1'b0}}};
        den_next[LANE_F12] = base + VW'(3);
        den_next[LANE_F16] = base + VW'(4);
        den_next[LANE_F32] = base + VW'(8);

        side_next.sectors = sec;
        side_next.cs      = cs;
        side_next.tiny    = tiny;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
        if (en) begin
            side_reg <= side_next;
            num_reg  <= num_next;
            den_reg  <= den_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_num   = num_reg;
    assign out_den   = den_reg;

endmodule

// ===== rtl/fvg_div.sv =====
module fvg_div
    import fvg_pkg::*;
#(
    parameter int SECTOR_BYTES = 512
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       en,
    input  logic                                       in_valid,
    input  side_t                                      in_side,
    input  logic [LANES-1:0][32+$clog2(SECTOR_BYTES)-1:0] in_num,
    input  logic [LANES-1:0][$clog2(SECTOR_BYTES)+8:0]    in_den,
    output logic                                       out_valid,
    output side_t                                      out_side,
    output logic [LANES-1:0][31:0]                     out_quo
);

    localparam int SBW = $clog2(SECTOR_BYTES);
    localparam int VW  = SBW + 9;
    localparam int NST = 32;

    logic                     vld_reg  [0:NST-1];
    side_t                    side_reg [0:NST-1];
    logic [LANES-1:0][VW-1:0] rem_reg  [0:NST-1];
    logic [LANES-1:0][VW-1:0] den_reg  [0:NST-1];
    logic [LANES-1:0][31:0]   num_reg  [0:NST-1];
    logic [LANES-1:0][31:0]   quo_reg  [0:NST-1];

    // One quotient bit per stage; the quotient is known to fit 32 bits,
    // so the top dividend bits seed the remainder.
    for (genvar s = 0; s < NST; s++) begin : g_stg
        logic                     src_vld;
        side_t                    src_side;
        logic [LANES-1:0][VW-1:0] src_rem, src_den;
        logic [LANES-1:0][31:0]   src_num, src_quo;
        logic [LANES-1:0][VW-1:0] rem_next;
        logic [LANES-1:0][31:0]   quo_next;

        if (s == 0) begin : g_first
            always_comb begin
                src_vld  = in_valid;
                src_side = in_side;
                src_den  = in_den;
                src_quo  = '0;
                for (int l = 0; l < LANES; l++) begin
                    src_rem[l] = VW'(in_num[l][32+SBW-1:32]);
                    src_num[l] = in_num[l][31:0];
                end
            end
        end else begin : g_next
            assign src_vld  = vld_reg[s-1];
            assign src_side = side_reg[s-1];
            assign src_rem  = rem_reg[s-1];
            assign src_den  = den_reg[s-1];
            assign src_num  = num_reg[s-1];
            assign src_quo  = quo_reg[s-1];
        end

        always_comb begin
            logic [VW:0] trial;
            logic [VW:0] diff;
            logic        ge;
            for (int l = 0; l < LANES; l++) begin
                trial = {src_rem[l], src_num[l][31]};
                diff  = trial - {1'b0, src_den[l]};
                ge    = trial >= {1'b0, src_den[l]};
                rem_next[l] = ge ? diff[VW-1:0] : trial[VW-1:0];
                quo_next[l] = {src_quo[l][30:0], ge};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s] <= 1'b0;
            end else if (en) begin
                vld_reg[s] <= src_vld;
            end
            if (en) begin
                side_reg[s] <= src_side;
                rem_reg[s]  <= rem_next;
                den_reg[s]  <= src_den;
                quo_reg[s]  <= quo_next;
                for (int l = 0; l < LANES; l++) begin
                    num_reg[s][l] <= {src_num[l][30:0], 1'b0};
                end
            end
        end
    end

    assign out_valid = vld_reg[NST-1];
    assign out_side  = side_reg[NST-1];
    assign out_quo   = quo_reg[NST-1];

endmodule

// ===== rtl/fvg_finish.sv =====
module fvg_finish
    import fvg_pkg::*;
#(
    parameter int SECTOR_BYTES = 512
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_valid,
    input  side_t                  in_side,
    input  logic [LANES-1:0][31:0] in_quo,
    output logic                   out_valid,
    output out_item_t              out_item
);

    localparam int SBW = $clog2(SECTOR_BYTES);

    logic      valid_reg;
    out_item_t item_reg, item_next;

    logic [34:0] half12, sum12, sum16, sum32;
    logic [34:0] len12, len16, len32;
    logic [18:0] clus_bytes;

    always_comb begin
        half12 = (35'(in_quo[LANE_F12]) * 35'd3 + 35'd1) >> 1;
        sum12  = half12 + 35'(SECTOR_BYTES - 1);
        sum16  = (35'(in_quo[LANE_F16]) << 1) + 35'(SECTOR_BYTES - 1);
        sum32  = (35'(in_quo[LANE_F32]) << 2) + 35'(SECTOR_BYTES - 1);
        len12  = sum12 >> SBW;
        len16  = sum16 >> SBW;
        len32  = sum32 >> SBW;
        clus_bytes = 19'(in_side.cs) << SBW;

        item_next.cluster_sectors = in_side.cs;
        item_next.too_small       = in_side.tiny;
        if (in_quo[LANE_F12] < F16_MIN_CLUSTERS) begin
            item_next.fat_kind      = FAT12;
            item_next.cluster_total = in_quo[LANE_F12];
            item_next.fat_sectors   = len12[25:0];
        end else if (in_quo[LANE_F16] < F32_MIN_CLUSTERS) begin
            item_next.fat_kind      = FAT16;
            item_next.cluster_total = in_quo[LANE_F16];
            item_next.fat_sectors   = len16[25:0];
        end else begin
            item_next.fat_kind      = FAT32;
            item_next.cluster_total = in_quo[LANE_F32];
            item_next.fat_sectors   = len32[25:0];
        end
        if (item_next.fat_kind == FAT32) begin
            item_next.reserved_sectors = 6'd32;
            item_next.root_dir_bytes   = clus_bytes[16:0];
        end else begin
            item_next.reserved_sectors = 6'd2;
            item_next.root_dir_bytes   = 17'(ROOT_BYTES);
        end
        if (in_side.sectors >= 32'd65536 || item_next.fat_kind == FAT32) begin
            item_next.short_sector_field = 16'd0;
            item_next.long_sector_field  = in_side.sectors;
        end else begin
            item_next.short_sector_field = in_side.sectors[15:0];
            item_next.long_sector_field  = 32'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
        if (en) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ===== rtl/fat_volume_geometry_top.sv =====
// FAT volume geometry planner. Each item carries a volume size in sectors and
// a requested cluster size (0 picks a default from the volume size); the
// result gives the FAT type, cluster count, FAT length, reserved sectors, root
// directory bytes and the 16/32-bit sector count fields, with a flag for
// volumes too small to hold the reserved and root directory sectors. One item
// is accepted per cycle while s_ready is high; each result passes through
// one decode stage, 32 stages of a radix-2 divider (one quotient bit
// per stage, three lanes for FAT12, FAT16 and FAT32 cluster counts), one
// stage that selects the FAT type and sizes the FAT, and the output register.
// A skid register behind the output keeps the pipeline moving under output
// stall until it catches an item; s_ready drops only once that register is full.
module fat_volume_geometry_top
    import fvg_pkg::*;
#(
    parameter int SECTOR_BYTES = 512
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    localparam int SBW = $clog2(SECTOR_BYTES);

    logic                         en;
    logic                         prep_valid;
    side_t                        prep_side;
    logic [LANES-1:0][32+SBW-1:0] prep_num;
    logic [LANES-1:0][SBW+8:0]    prep_den;
    logic                         div_valid;
    side_t                        div_side;
    logic [LANES-1:0][31:0]       div_quo;
    logic                         fin_valid;
    out_item_t                    fin_item;

    logic      m_valid_reg;
    out_item_t m_item_reg;
    logic      skid_valid_reg;
    out_item_t skid_item_reg;

    // Advance the whole pipeline unless the skid register holds an item
    assign en      = !skid_valid_reg;
    assign s_ready = en;

    fvg_prep #(.SECTOR_BYTES(SECTOR_BYTES)) u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_item   (s_item),
        .out_valid (prep_valid),
        .out_side  (prep_side),
        .out_num   (prep_num),
        .out_den   (prep_den)
    );

    fvg_div #(.SECTOR_BYTES(SECTOR_BYTES)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (prep_valid),
        .in_side   (prep_side),
        .in_num    (prep_num),
        .in_den    (prep_den),
        .out_valid (div_valid),
        .out_side  (div_side),
        .out_quo   (div_quo)
    );

    fvg_finish #(.SECTOR_BYTES(SECTOR_BYTES)) u_finish (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (div_valid),
        .in_side   (div_side),
        .in_quo    (div_quo),
        .out_valid (fin_valid),
        .out_item  (fin_item)
    );

    // Output register with a skid stage behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_ready || !m_valid_reg) begin
            if (skid_valid_reg) begin
                // drain the skid item first; the pipeline is frozen meanwhile
                m_item_reg     <= skid_item_reg;
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_item_reg  <= fin_item;
                m_valid_reg <= fin_valid;
            end
        end else if (fin_valid && !skid_valid_reg) begin
            // hold the item leaving the pipeline while the output stalls
            skid_item_reg  <= fin_item;
            skid_valid_reg <= 1'b1;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

`ifndef NO_ASSERTIONS
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid register full with empty output");

    a_skid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && !m_ready |=> skid_valid_reg && $stable(skid_item_reg))
        else $error("skid item lost during stall");

    a_fat32_reserved: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_item.fat_kind == FAT32) == (m_item.reserved_sectors == 6'd32)))
        else $error("reserved sectors disagree with FAT type");

    a_small_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.too_small |-> m_item.cluster_total == 32'd0
            && m_item.fat_kind == FAT12)
        else $error("tiny volume reports clusters");
`endif

endmodule
